>>> design/tlca_pkg.sv
// Package for the binary-lifting lowest common ancestor block.
// Holds the node, depth and table-row types, sizes and request codes.
// No dependencies.
package tlca_pkg;

   localparam int NODE_W      = 10;
   localparam int NODE_COUNT  = 2 ** NODE_W;
   localparam int LIFT_LEVELS = 10;
   localparam int DEPTH_W     = 10;
   localparam int LVL_W       = $clog2(LIFT_LEVELS);
   localparam int ROW_W       = DEPTH_W + LIFT_LEVELS * NODE_W;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [LVL_W-1:0]   lvl_type;

   localparam depth_type DEPTH_MAX = '1;
   localparam lvl_type   LAST_LVL  = LVL_W'(LIFT_LEVELS - 1);

   // One table row per node: its depth and its ancestors at distance 2^i.
   typedef struct packed {
      depth_type                   depth;
      node_type [LIFT_LEVELS-1:0]  anc;
   } row_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

endpackage

>>> design/tlca_ram.sv
// Generic synchronous RAM: one write port and two read ports.
// Read data is registered, so it appears in the cycle after the address.
// No dependencies.
module tlca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> design/tree_lca_binary_lifting.sv
// Top level of the binary-lifting lowest common ancestor block.
// Holds the request sequencer and the result register; uses tlca_pkg
// and one tlca_ram instance for the node table.
//
// An insert request (req_type 0) stores req_node_a under parent req_node_b,
// parent 0 marking the root; parents must come before their children and an
// insert of node 0 is ignored. A query request (req_type 1) returns the lowest
// common ancestor of its two nodes as rsp_common_ancestor, on rsp_valid/rsp_stall.
//
// One request is handled at a time; each level step waits on the registered
// read of the table RAM. An insert makes a parent row read, nine dependent
// reads for levels one to nine and a return to idle. A query loads its
// response after row reads, ten lift steps, ten joint steps and a final
// parent read; when the lifted node already equals the other one it loads
// straight after the lift steps.
//
// After reset the 1024 table rows are swept to zero, one per cycle, with
// req_stall high. A response waits in its register while rsp_stall is high;
// new requests are still accepted, and only a later query waits for it.
module tree_lca_binary_lifting (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  tlca_pkg::node_type req_node_a,
   input  tlca_pkg::node_type req_node_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlca_pkg::node_type rsp_common_ancestor
);

   import tlca_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FIRST = 3'd2;
   localparam logic [2:0] S_INS   = 3'd3;
   localparam logic [2:0] S_LIFT  = 3'd4;
   localparam logic [2:0] S_LCA   = 3'd5;
   localparam logic [2:0] S_FINAL = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   node_type   clr_ff, clr_in;
   lvl_type    lvl_ff, lvl_in;
   logic       op_ff, op_in;

   // x and y are the two walking nodes; their next values drive the RAM read ports.
   node_type   x_ff, x_in;
   node_type   y_ff, y_in;
   depth_type  dy_ff, dy_in;

   // The row under construction during an insert.
   node_type                   u_ff, u_in;
   depth_type                  dep_ff, dep_in;
   node_type [LIFT_LEVELS-1:0] anc_ff, anc_in;

   node_type   res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   node_type   rsp_ca_ff, rsp_ca_in;

   row_type    row_a, row_b, wr_row;
   logic       wr_en;
   node_type   wr_addr;

   lvl_type              lvl_m1;
   logic [DEPTH_W:0]     step;
   node_type             ins_val;
   node_type             lift_x;
   logic                 rsp_free;

   tlca_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODE_COUNT)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_row),
      .rd_addr_a (x_in),
      .rd_data_a (row_a),
      .rd_addr_b (y_in),
      .rd_data_b (row_b)
   );

   assign lvl_m1   = lvl_ff - 1'b1;
   assign step     = (DEPTH_W + 1)'(1) << lvl_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Insert level: the 2^i-th ancestor is the 2^(i-1)-th ancestor of the current
   // midpoint, or zero past the new depth. When the midpoint is the node being
   // inserted, its new entry is not in the RAM yet; it equals the midpoint itself.
   always_comb begin
      if (step <= {1'b0, dep_ff}) begin
         if (x_ff == u_ff) begin
            ins_val = x_ff;
         end else begin
            ins_val = row_a.anc[lvl_m1];
         end
      end else begin
         ins_val = '0;
      end
   end

   // Lift the deeper node while it stays at or below the other's depth.
   always_comb begin
      if ({1'b0, row_a.depth} >= ({1'b0, dy_ff} + step)) begin
         lift_x = row_a.anc[lvl_ff];
      end else begin
         lift_x = x_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lvl_in       = lvl_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dy_in        = dy_ff;
      u_in         = u_ff;
      dep_in       = dep_ff;
      anc_in       = anc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ca_in    = rsp_ca_ff;
      wr_en        = 1'b0;
      wr_addr      = u_ff;
      wr_row       = '0;
      req_stall    = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Keep both RAM ports on the request so the rows are ready next cycle.
            req_stall = 1'b0;
            x_in      = req_node_a;
            y_in      = req_node_b;
            op_in     = req_type;
            if (req_valid) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (op_ff == OP_INSERT) begin
               if (x_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  u_in      = x_ff;
                  dep_in    = (row_b.depth == DEPTH_MAX) ? DEPTH_MAX
                                                         : row_b.depth + 1'b1;
                  anc_in    = '0;
                  anc_in[0] = y_ff;
                  x_in      = y_ff;
                  lvl_in    = lvl_type'(1);
                  state_in  = S_INS;
               end
            end else begin
               // The deeper node walks as x.
               if (row_a.depth < row_b.depth) begin
                  x_in  = y_ff;
                  y_in  = x_ff;
                  dy_in = row_a.depth;
               end else begin
                  dy_in = row_b.depth;
               end
               lvl_in   = LAST_LVL;
               state_in = S_LIFT;
            end
         end
         S_INS: begin
            anc_in[lvl_ff] = ins_val;
            x_in           = ins_val;
            lvl_in         = lvl_ff + 1'b1;
            if (lvl_ff == LAST_LVL) begin
               wr_en    = 1'b1;
               wr_addr  = u_ff;
               wr_row.depth = dep_ff;
               wr_row.anc   = anc_ff;
               wr_row.anc[LIFT_LEVELS-1] = ins_val;
               state_in = S_IDLE;
            end
         end
         S_LIFT: begin
            x_in   = lift_x;
            lvl_in = lvl_ff - 1'b1;
            if (lvl_ff == '0) begin
               if (lift_x == y_ff) begin
                  res_in   = lift_x;
                  state_in = S_DONE;
               end else begin
                  lvl_in   = LAST_LVL;
                  state_in = S_LCA;
               end
            end
         end
         S_LCA: begin
            if (row_a.anc[lvl_ff] != row_b.anc[lvl_ff]) begin
               x_in = row_a.anc[lvl_ff];
               y_in = row_b.anc[lvl_ff];
            end
            lvl_in = lvl_ff - 1'b1;
            if (lvl_ff == '0) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            res_in   = row_a.anc[0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ca_in    = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      op_ff     <= op_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      dy_ff     <= dy_in;
      u_ff      <= u_in;
      dep_ff    <= dep_in;
      anc_ff    <= anc_in;
      res_ff    <= res_in;
      rsp_ca_ff <= rsp_ca_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_common_ancestor = rsp_ca_ff;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the binary-lifting lowest common ancestor block.
// Drives insert and query requests, predicts each ancestor internally and checks
// every response. Depends on tlca_pkg and tree_lca_binary_lifting.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tlca_pkg::*;

   // The run is cut off here if it has not finished. The slowest correct run is
   // roughly 1800 requests plus idling, stalls and the clearing sweep after
   // reset, and stays well within the limit.
   localparam int CYCLE_LIMIT   = 400_000;
   // Quiet cycles after the last response, enough to cover a full query.
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic     op;
      node_type a;
      node_type b;
   } lca_request_type;

   // Clock, reset and every block input start at known values.
   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_valid  = 1'b0;
   logic     req_type   = OP_INSERT;
   node_type req_node_a = '0;
   node_type req_node_b = '0;
   logic     rsp_stall  = 1'b0;
   logic     req_stall;
   logic     rsp_valid;
   node_type rsp_common_ancestor;

   // Idling controls, in percent of cycles, set per traffic phase.
   int gap_pct   = 0;
   int stall_pct = 0;

   // Requests still to be offered, and ancestors owed by accepted queries.
   lca_request_type pending_requests [$];
   node_type        expected_ancestors [$];

   // The testbench's own copy of the tree: depth per node and the jump table,
   // where entry lvl of a node is its ancestor 2**lvl levels up.
   depth_type tree_depth [NODE_COUNT];
   node_type  tree_jump  [NODE_COUNT][LIFT_LEVELS];

   int cycle_count    = 0;
   int error_count    = 0;
   int insert_count   = 0;
   int query_count    = 0;
   int response_count = 0;
   int deepest_depth  = 0;

   tree_lca_binary_lifting dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_common_ancestor (rsp_common_ancestor)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Attach a node under its parent. Node zero is the sentinel and is never
   // touched. Depth saturates at the top of its range. The jump entries are
   // built from whatever the parent's row holds right now, so out-of-order
   // and repeated inserts land exactly as the hardware would store them.
   function automatic void attach_node(node_type child, node_type parent);
      int unsigned new_depth;
      node_type    hop;
      int          lvl;
      if (child == '0) begin
         return;
      end
      new_depth = int'(tree_depth[parent]) + 1;
      if (new_depth > DEPTH_MAX) begin
         new_depth = DEPTH_MAX;
      end
      if (int'(new_depth) > deepest_depth) begin
         deepest_depth = new_depth;
      end
      tree_depth[child]   = depth_type'(new_depth);
      tree_jump[child][0] = parent;
      for (lvl = 1; lvl < LIFT_LEVELS; lvl++) begin
         if ((1 << lvl) <= new_depth) begin
            hop = tree_jump[child][lvl-1];
            tree_jump[child][lvl] = tree_jump[hop][lvl-1];
         end else begin
            tree_jump[child][lvl] = '0;
         end
      end
   endfunction

   // Lift the deeper node to the other's depth, then lift both while their
   // ancestors differ. The same fixed steps run on any stored contents,
   // including nodes that were never inserted.
   function automatic node_type lowest_ancestor(node_type x, node_type y);
      node_type swap_node;
      int       lvl;
      if (tree_depth[x] < tree_depth[y]) begin
         swap_node = x;
         x = y;
         y = swap_node;
      end
      for (lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
         if (int'(tree_depth[x]) - (1 << lvl) >= int'(tree_depth[y])) begin
            x = tree_jump[x][lvl];
         end
      end
      if (x == y) begin
         return x;
      end
      for (lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
         if (tree_jump[x][lvl] != tree_jump[y][lvl]) begin
            x = tree_jump[x][lvl];
            y = tree_jump[y][lvl];
         end
      end
      return tree_jump[x][0];
   endfunction

   function automatic void note_failure(string what, node_type want, node_type got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("[%0t] ERROR: %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   function automatic void queue_request(logic op, node_type a, node_type b);
      lca_request_type req;
      req.op = op;
      req.a  = a;
      req.b  = b;
      pending_requests.insert(pending_requests.size(), req);
   endfunction

   // Driver. A request is accepted on a rising edge with valid high and stall
   // low; at that edge the predictor applies it in acceptance order. While
   // stalled the request is held unchanged. Each signal gets at most one
   // nonblocking assignment per edge.
   always @(posedge clock) begin : request_driver
      lca_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_type == OP_INSERT) begin
               insert_count++;
               attach_node(req_node_a, req_node_b);
            end else begin
               query_count++;
               expected_ancestors.insert(expected_ancestors.size(),
                                         lowest_ancestor(req_node_a, req_node_b));
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
               next_req = pending_requests.pop_front();
               req_type   <= next_req.op;
               req_node_a <= next_req.a;
               req_node_b <= next_req.b;
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every accepted response is matched against the oldest query
   // still owed; stall is redrawn every cycle from the current stall rate.
   always @(posedge clock) begin : response_monitor
      node_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_ancestors.size() == 0) begin
               note_failure("response with no query outstanding", '0, rsp_common_ancestor);
            end else begin
               want = expected_ancestors.pop_front();
               if (rsp_common_ancestor !== want) begin
                  note_failure("common_ancestor mismatch", want, rsp_common_ancestor);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Grow one tree from a shuffled set of node numbers. Parents mostly come
   // from nodes already inserted in this tree, so parents precede children;
   // a chain-heavy bias gives deep trees. Unless a pure chain is asked for, a
   // few inserts get a random parent (possibly one not yet inserted) and a few
   // target the sentinel. Queries are mixed in as the tree grows.
   task automatic plant_tree(input int node_total, input bit pure_chain, input int query_pct,
                             output node_type grown [$]);
      node_type order [1023];
      node_type child;
      node_type parent;
      node_type swap_node;
      node_type qa;
      node_type qb;
      int       k;
      int       pick;
      grown.delete();
      for (k = 0; k < 1023; k++) begin
         order[k] = node_type'(k + 1);
      end
      for (k = 1022; k > 0; k--) begin
         pick        = $urandom_range(k);
         swap_node   = order[k];
         order[k]    = order[pick];
         order[pick] = swap_node;
      end
      for (k = 0; k < node_total; k++) begin
         child = order[k];
         if (grown.size() == 0) begin
            parent = '0;
         end else if (pure_chain || $urandom_range(99) < 40) begin
            parent = grown[grown.size()-1];
         end else begin
            parent = grown[$urandom_range(grown.size() - 1)];
         end
         if (!pure_chain && $urandom_range(99) < 4) begin
            parent = node_type'($urandom);
         end
         queue_request(OP_INSERT, child, parent);
         grown.insert(grown.size(), child);
         if (!pure_chain && $urandom_range(99) < 3) begin
            queue_request(OP_INSERT, '0, node_type'($urandom));
         end
         if ($urandom_range(99) < query_pct) begin
            qa = grown[$urandom_range(grown.size() - 1)];
            qb = grown[$urandom_range(grown.size() - 1)];
            case ($urandom_range(9))
               0: qa = node_type'($urandom);
               1: qb = qa;
               2: qb = '0;
               default: ;
            endcase
            queue_request(OP_QUERY, qa, qb);
         end
      end
   endtask

   // Wait until every request has gone in and every response has come back,
   // then give the block time to finish an insert that owes no response.
   task automatic drain_traffic();
      while (pending_requests.size() != 0 || req_valid || expected_ancestors.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d queries unanswered",
               cycle_count, expected_ancestors.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      node_type grown [$];
      node_type deepest;
      node_type lifted;
      int       phase;
      int       n;

      for (n = 0; n < NODE_COUNT; n++) begin
         tree_depth[n] = '0;
         for (int lvl = 0; lvl < LIFT_LEVELS; lvl++) begin
            tree_jump[n][lvl] = '0;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with no idling. Queries on an empty tree, the sentinel
      // insert, a small hand-built tree, the top node number, an unknown node,
      // a parent that was never inserted, a re-insert and a self-parent.
      queue_request(OP_QUERY,  10'd0,    10'd0);
      queue_request(OP_QUERY,  10'd1023, 10'd0);
      queue_request(OP_INSERT, 10'd0,    10'd5);
      queue_request(OP_INSERT, 10'd1,    10'd0);
      queue_request(OP_INSERT, 10'd2,    10'd1);
      queue_request(OP_INSERT, 10'd3,    10'd1);
      queue_request(OP_INSERT, 10'd4,    10'd2);
      queue_request(OP_INSERT, 10'd1023, 10'd4);
      queue_request(OP_QUERY,  10'd4,    10'd3);
      queue_request(OP_QUERY,  10'd1023, 10'd3);
      queue_request(OP_QUERY,  10'd1023, 10'd1023);
      queue_request(OP_QUERY,  10'd2,    10'd1023);
      queue_request(OP_QUERY,  10'd1,    10'd0);
      queue_request(OP_QUERY,  10'd0,    10'd1023);
      queue_request(OP_QUERY,  10'd500,  10'd4);
      queue_request(OP_INSERT, 10'd6,    10'd7);
      queue_request(OP_QUERY,  10'd6,    10'd4);
      queue_request(OP_INSERT, 10'd2,    10'd3);
      queue_request(OP_QUERY,  10'd4,    10'd2);
      queue_request(OP_INSERT, 10'd1023, 10'd1023);
      queue_request(OP_QUERY,  10'd1023, 10'd1);
      queue_request(OP_INSERT, 10'd512,  10'd682);
      queue_request(OP_QUERY,  10'd341,  10'd512);
      drain_traffic();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 51; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         if (phase == 0) begin
            // One chain through every node reaches the top depth, so queries
            // use every lift level. Hanging a node below the deepest one then
            // pushes its depth past the maximum, where it must saturate.
            plant_tree(1023, 1'b1, 8, grown);
            deepest = grown[1022];
            lifted  = grown[$urandom_range(400, 1000)];
            queue_request(OP_INSERT, lifted, deepest);
            queue_request(OP_QUERY,  lifted, deepest);
            queue_request(OP_QUERY,  lifted, grown[0]);
            queue_request(OP_QUERY,  deepest, grown[$urandom_range(1021)]);
            queue_request(OP_INSERT, deepest, deepest);
            queue_request(OP_QUERY,  deepest, lifted);
         end else begin
            plant_tree(180, 1'b0, 25, grown);
         end
         drain_traffic();
      end

      if (expected_ancestors.size() != 0) begin
         error_count += expected_ancestors.size();
         $display("%0d queries were never answered", expected_ancestors.size());
      end
      $display("Ran %0d inserts and %0d queries, checked %0d responses; trees reached depth %0d.",
               insert_count, query_count, response_count, deepest_depth);
      $display("Traffic covered no idling, sender gaps, receiver stalls and both; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/tlca_pkg.sv
design/tlca_ram.sv
design/tree_lca_binary_lifting.sv
tb/sv/testbench.sv
